FILE: src/tgem_pkg.sv
// Shared constants, types and helpers for the tile grid edge merger.
package tgem_pkg;

  localparam int GRID    = 32;
  localparam int RC_W    = $clog2(GRID);
  localparam int TILE_W  = RC_W + 1;
  localparam int CS_W    = 7;
  localparam int COORD_W = 12;
  localparam int PROD_W  = (TILE_W + CS_W > COORD_W) ? TILE_W + CS_W : COORD_W;
  localparam int NKIND   = 8;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE  = '0;
  localparam logic [CS_W-1:0]      CELL_SIZE_RST  = CS_W'(30);

  // Edge kinds in emission order within one tile.
  typedef enum logic [2:0] {
    K_LEFT       = 3'd0,
    K_RIGHT      = 3'd1,
    K_TOP        = 3'd2,
    K_BOTTOM     = 3'd3,
    K_BORDER_L   = 3'd4,
    K_BORDER_T   = 3'd5,
    K_BORDER_R   = 3'd6,
    K_BORDER_B   = 3'd7
  } kind_t;

  // Closed runs caused by one tile, waiting to be turned into edges.
  typedef struct packed {
    logic [NKIND-1:0] mask;
    logic [RC_W-1:0]  col;
    logic [RC_W-1:0]  row;
    logic [RC_W-1:0]  left_start;
    logic [RC_W-1:0]  right_start;
    logic [RC_W-1:0]  top_start;
    logic [RC_W-1:0]  bottom_start;
  } event_t;

  // Tile index to pixel coordinate, wrapped to the coordinate width.
  function automatic logic [COORD_W-1:0] pix(input logic [TILE_W-1:0] t,
                                             input logic [CS_W-1:0] cs);
    logic [PROD_W-1:0] p;
    p = PROD_W'(t) * PROD_W'(cs);
    return p[COORD_W-1:0];
  endfunction

endpackage

FILE: src/tgem_if.sv
// Stream interfaces for tile input and edge output.
interface tgem_tile_if;
  logic valid;
  logic ready;
  logic cell_present;

  modport source (output valid, output cell_present, input ready);
  modport sink (input valid, input cell_present, output ready);
endinterface

interface tgem_edge_if;
  import tgem_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic               last_of_item;
  logic               frame_done;

  modport source (output valid, output x_start, output y_start, output x_end,
                  output y_end, output last_of_item, output frame_done,
                  input ready);
  modport sink (input valid, input x_start, input y_start, input x_end,
                input y_end, input last_of_item, input frame_done,
                output ready);
endinterface

FILE: src/tile_grid_edge_merge.sv
// Tile grid edge merger top level: config register, scan tracker, edge drain.
// Path: a tile transfer that closes a run writes its event into the queue, then the edge
//   is registered at the output; further edges of that tile follow one a cycle when ready.
// Throughput: one tile transfer per cycle while the four-entry event queue has room;
//   edges drain one per cycle when ready (up to eight on the last tile), which sets the rate.
// Reset (rst, synchronous): position, row bits, run valids, queue, output clear; cell_size 30.
module tile_grid_edge_merge (
  input  logic                            clk,
  input  logic                            rst,
  tgem_tile_if.sink                       tiles,
  tgem_edge_if.source                     edges,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tgem_pkg::PADDR_W-1:0]    paddr,
  input  logic [tgem_pkg::PDATA_W-1:0]    pwdata,
  output logic [tgem_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import tgem_pkg::*;

  logic [CS_W-1:0]      cell_size;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 accept;
  logic                 can_push;
  event_t               ev;

  // APB: zero wait states, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign prdata  = (reg_idx == REG_CELL_SIZE) ? PDATA_W'(cell_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RST;
    end else if (psel && penable && pwrite && (reg_idx == REG_CELL_SIZE)) begin
      cell_size <= pwdata[CS_W-1:0];
    end
  end

  // A tile transfer updates the run state at once; only tiles that close
  // at least one run (or end the frame) put an event into the queue.
  assign tiles.ready = can_push;
  assign accept      = tiles.valid && tiles.ready;

  tgem_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .cell_present (tiles.cell_present),
    .ev           (ev)
  );

  tgem_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && (ev.mask != '0)),
    .ev_in     (ev),
    .cell_size (cell_size),
    .can_push  (can_push),
    .edges     (edges)
  );

endmodule

FILE: src/tgem_scan.sv
// Raster position, occupancy history and open run tracking.
module tgem_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            cell_present,
  output tgem_pkg::event_t ev
);
  import tgem_pkg::*;

  logic [RC_W-1:0] row;
  logic [RC_W-1:0] col;
  logic [GRID-1:0] above_bits;
  logic            prev_cur;
  logic [GRID-1:0] left_valid;
  logic [GRID-1:0] right_valid;
  logic            top_valid;
  logic            bottom_valid;
  logic [RC_W-1:0] left_start   [GRID];
  logic [RC_W-1:0] right_start  [GRID];
  logic [RC_W-1:0] top_start;
  logic [RC_W-1:0] bottom_start;

  logic [RC_W-1:0] col_m1;
  logic ring, cur, up, lft, last_tile;
  logic lf, rf, tf, bf;
  logic cl_left, cl_right, cl_top, cl_bottom;

  assign col_m1    = col - 1'b1;
  assign ring      = (row == '0) || (row == RC_W'(GRID - 1)) ||
                     (col == '0) || (col == RC_W'(GRID - 1));
  assign cur       = cell_present && !ring;
  assign up        = (row != '0) && above_bits[col];
  assign lft       = (col != '0) && prev_cur;
  assign last_tile = (row == RC_W'(GRID - 1)) && (col == RC_W'(GRID - 1));

  // faces of the current tile pair
  assign lf = cur && !lft;
  assign rf = lft && !cur;
  assign tf = cur && !up;
  assign bf = up && !cur;

  assign cl_left   = !lf && left_valid[col];
  assign cl_right  = (col != '0) && !rf && right_valid[col_m1];
  assign cl_top    = !tf && top_valid;
  assign cl_bottom = !bf && bottom_valid;

  always_comb begin
    ev.mask         = {{4{last_tile}}, cl_bottom, cl_top, cl_right, cl_left};
    ev.col          = col;
    ev.row          = row;
    ev.left_start   = left_start[col];
    ev.right_start  = right_start[col_m1];
    ev.top_start    = top_start;
    ev.bottom_start = bottom_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= '0;
      col          <= '0;
      above_bits   <= '0;
      prev_cur     <= 1'b0;
      left_valid   <= '0;
      right_valid  <= '0;
      top_valid    <= 1'b0;
      bottom_valid <= 1'b0;
    end else if (push) begin
      above_bits[col] <= cur;
      prev_cur        <= cur;
      if (lf) begin
        left_valid[col] <= 1'b1;
      end else begin
        left_valid[col] <= 1'b0;
      end
      if (col != '0) begin
        right_valid[col_m1] <= rf;
      end
      top_valid    <= tf;
      bottom_valid <= bf;
      if (col == RC_W'(GRID - 1)) begin
        col <= '0;
        if (row == RC_W'(GRID - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // run start points: written only when a run opens
  always_ff @(posedge clk) begin
    if (push) begin
      if (lf && !left_valid[col]) begin
        left_start[col] <= row;
      end
      if ((col != '0) && rf && !right_valid[col_m1]) begin
        right_start[col_m1] <= row;
      end
      if (tf && !top_valid) begin
        top_start <= col;
      end
      if (bf && !bottom_valid) begin
        bottom_start <= col;
      end
    end
  end

endmodule

FILE: src/tgem_drain.sv
// Event queue and edge output register: one edge per cycle while the sink is ready.
module tgem_drain (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  tgem_pkg::event_t             ev_in,
  input  logic [tgem_pkg::CS_W-1:0]    cell_size,
  output logic                         can_push,
  tgem_edge_if.source                  edges
);
  import tgem_pkg::*;

  event_t           q [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] cnt;

  event_t           head_ev;
  logic             head_valid;
  logic             load;
  logic [NKIND-1:0] sel;
  logic [NKIND-1:0] rest;
  logic             last_item;
  logic             pop;
  kind_t            kind;
  logic [TILE_W-1:0] xs, ys, xe, ye;
  logic [TILE_W-1:0] c_t, r_t, g_t;

  assign can_push   = (cnt != QCNT_W'(QDEPTH));
  assign head_ev    = q[head];
  assign head_valid = (cnt != '0);
  assign load       = head_valid && (!edges.valid || edges.ready);
  assign sel        = head_ev.mask & (~head_ev.mask + 1'b1);
  assign rest       = head_ev.mask & ~sel;
  assign last_item  = (rest == '0);
  assign pop        = load && last_item;

  always_comb begin
    kind = K_LEFT;
    for (int k = 0; k < NKIND; k++) begin
      if (sel[k]) kind = kind_t'(3'(k));
    end
  end

  assign c_t = {1'b0, head_ev.col};
  assign r_t = {1'b0, head_ev.row};
  assign g_t = TILE_W'(GRID);

  always_comb begin
    case (kind)
      K_LEFT: begin
        xs = c_t; ys = {1'b0, head_ev.left_start}; xe = c_t; ye = r_t;
      end
      K_RIGHT: begin
        xs = c_t; ys = {1'b0, head_ev.right_start}; xe = c_t; ye = r_t;
      end
      K_TOP: begin
        xs = {1'b0, head_ev.top_start}; ys = r_t; xe = c_t; ye = r_t;
      end
      K_BOTTOM: begin
        xs = {1'b0, head_ev.bottom_start}; ys = r_t; xe = c_t; ye = r_t;
      end
      K_BORDER_L: begin
        xs = '0; ys = '0; xe = '0; ye = g_t;
      end
      K_BORDER_T: begin
        xs = '0; ys = '0; xe = g_t; ye = '0;
      end
      K_BORDER_R: begin
        xs = g_t; ys = '0; xe = g_t; ye = g_t;
      end
      K_BORDER_B: begin
        xs = '0; ys = g_t; xe = g_t; ye = g_t;
      end
      default: begin
        xs = '0; ys = '0; xe = '0; ye = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      cnt         <= '0;
      edges.valid <= 1'b0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QDEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == QPTR_W'(QDEPTH - 1)) ? '0 : head + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
      if (load) begin
        edges.valid <= 1'b1;
      end else if (edges.ready) begin
        edges.valid <= 1'b0;
      end
    end
  end

  // queue payload and output payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= ev_in;
    end
    if (load && !last_item) begin
      q[head].mask <= rest;
    end
    if (load) begin
      edges.x_start      <= pix(xs, cell_size);
      edges.y_start      <= pix(ys, cell_size);
      edges.x_end        <= pix(xe, cell_size);
      edges.y_end        <= pix(ye, cell_size);
      edges.last_of_item <= last_item;
      edges.frame_done   <= (kind == K_BORDER_B);
    end
  end

endmodule

FILE: src/tgem_checker.sv
// Port-level assertions for the tile grid edge merger, bound to the top level.
module tgem_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tgem_pkg::COORD_W-1:0] x_start,
  input logic [tgem_pkg::COORD_W-1:0] y_start,
  input logic [tgem_pkg::COORD_W-1:0] y_end,
  input logic                         last_of_item,
  input logic                         frame_done
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_start) && $stable(y_end))
    else $error("edge output changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("edge output valid right after reset");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_item)
    else $error("frame_done edge not marked last of its tile");

  a_frame_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> (x_start == '0) && (y_start == y_end))
    else $error("frame_done edge is not the bottom border");

endmodule

bind tile_grid_edge_merge tgem_checker u_tgem_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (edges.valid),
  .out_ready    (edges.ready),
  .x_start      (edges.x_start),
  .y_start      (edges.y_start),
  .y_end        (edges.y_end),
  .last_of_item (edges.last_of_item),
  .frame_done   (edges.frame_done)
);
